### hw/rtl/vwap_crossover_signal_defines.svh
// ----------------------------------------------------------------------------
// VWAP crossover signal: assertion macros
// Concurrent checks on the rising clock with asynchronous reset disable.
// ----------------------------------------------------------------------------
`ifndef VWAP_CROSSOVER_SIGNAL_DEFINES_SVH
`define VWAP_CROSSOVER_SIGNAL_DEFINES_SVH

`ifndef SYNTHESIS
`define VCS_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("vcs assertion failed");
`define VCS_ASSERT_NEVER(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) \
		else $error("vcs forbidden condition seen");
`else
`define VCS_ASSERT(label, clk, rst_n, prop)
`define VCS_ASSERT_NEVER(label, clk, rst_n, prop)
`endif

`endif

### hw/rtl/vcs_pkg.sv
// ----------------------------------------------------------------------------
// VWAP crossover signal package
// Widths, register map, signal codes and the divider handshake types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package vcs_pkg;

	localparam int PRICE_W = 32;
	localparam int TURN_W  = 63;
	localparam int VOL_W   = 32;
	localparam int MULT_W  = 16;
	localparam int PROD_W  = VOL_W + MULT_W;
	localparam int SIG_W   = 2;
	localparam int CNT_W   = 6;
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;

	localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(MULT_W - 1);
	localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(TURN_W - 1);

	// register index taken from paddr[2]
	localparam logic REG_VOLUME_MULT = 1'b0;
	localparam logic [MULT_W-1:0] VOLUME_MULT_RST = MULT_W'(1);

	localparam logic [SIG_W-1:0] SIG_NONE = 2'd0;
	localparam logic [SIG_W-1:0] SIG_BUY  = 2'd1;
	localparam logic [SIG_W-1:0] SIG_SELL = 2'd2;

	typedef struct packed {
		logic start;
		logic ack;
	} vcs_div_ctrl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} vcs_div_stat_t;

endpackage

`default_nettype wire

### hw/rtl/vcs_divider.sv
// ----------------------------------------------------------------------------
// VWAP crossover signal: iterative average unit
// One shared 49-bit adder/subtractor: shift-add multiply of volume by the
// multiplier, then restoring divide of turnover.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "vwap_crossover_signal_defines.svh"

module vcs_divider (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire vcs_pkg::vcs_div_ctrl_t       ctrl,
	input  wire logic [vcs_pkg::TURN_W-1:0]   dividend,
	input  wire logic [vcs_pkg::VOL_W-1:0]    volume,
	input  wire logic [vcs_pkg::MULT_W-1:0]   mult,
	output vcs_pkg::vcs_div_stat_t            stat,
	output logic      [vcs_pkg::TURN_W-1:0]   quotient
);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_MUL  = 4'b0010,
		ST_DIV  = 4'b0100,
		ST_DONE = 4'b1000
	} state_t;

	state_t                        state_q;
	logic [vcs_pkg::CNT_W-1:0]     cnt_q;
	logic [vcs_pkg::PROD_W-1:0]    acc_q;
	logic [vcs_pkg::PROD_W-1:0]    mcand_q;
	logic [vcs_pkg::MULT_W-1:0]    mplier_q;
	logic [vcs_pkg::PROD_W-1:0]    divisor_q;
	logic [vcs_pkg::TURN_W-1:0]    dvd_q;

	logic                          op_sub;
	logic [vcs_pkg::PROD_W:0]      trial;
	logic [vcs_pkg::PROD_W:0]      alu_a;
	logic [vcs_pkg::PROD_W:0]      alu_b;
	logic [vcs_pkg::PROD_W+1:0]    alu_sum;
	logic                          ge;

	// shared adder/subtractor
	assign op_sub  = (state_q == ST_DIV);
	assign trial   = {acc_q, dvd_q[vcs_pkg::TURN_W-1]};
	assign alu_a   = op_sub ? trial : {1'b0, acc_q};
	assign alu_b   = op_sub ? {1'b0, divisor_q} : {1'b0, mcand_q};
	assign alu_sum = {1'b0, alu_a} + {1'b0, alu_b ^ {(vcs_pkg::PROD_W+1){op_sub}}}
		+ (vcs_pkg::PROD_W+2)'(op_sub);
	assign ge      = alu_sum[vcs_pkg::PROD_W+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (ctrl.start) begin
						state_q <= ST_MUL;
						cnt_q   <= '0;
					end
				end
				ST_MUL: begin
					if (cnt_q == vcs_pkg::MUL_LAST) begin
						state_q <= ST_DIV;
						cnt_q   <= '0;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_DIV: begin
					if (cnt_q == vcs_pkg::DIV_LAST) begin
						state_q <= ST_DONE;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_DONE: begin
					if (ctrl.ack) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (ctrl.start) begin
					acc_q    <= '0;
					mcand_q  <= {{vcs_pkg::MULT_W{1'b0}}, volume};
					mplier_q <= mult;
					dvd_q    <= dividend;
				end
			end
			ST_MUL: begin
				mcand_q  <= {mcand_q[vcs_pkg::PROD_W-2:0], 1'b0};
				mplier_q <= {1'b0, mplier_q[vcs_pkg::MULT_W-1:1]};
				if (cnt_q == vcs_pkg::MUL_LAST) begin
					divisor_q <= mplier_q[0] ? alu_sum[vcs_pkg::PROD_W-1:0] : acc_q;
					acc_q     <= '0;
				end else if (mplier_q[0]) begin
					acc_q <= alu_sum[vcs_pkg::PROD_W-1:0];
				end
			end
			ST_DIV: begin
				acc_q <= ge ? alu_sum[vcs_pkg::PROD_W-1:0] : trial[vcs_pkg::PROD_W-1:0];
				dvd_q <= {dvd_q[vcs_pkg::TURN_W-2:0], ge};
			end
			default: begin
			end
		endcase
	end

	assign stat.busy = (state_q != ST_IDLE);
	assign stat.done = (state_q == ST_DONE);
	assign quotient  = (divisor_q == '0) ? '0 : dvd_q;

	`VCS_ASSERT(a_mul_to_div, clk, arst_n,
		(state_q == ST_MUL && cnt_q == vcs_pkg::MUL_LAST) |=> (state_q == ST_DIV))
	`VCS_ASSERT(a_rem_below_divisor, clk, arst_n,
		(state_q == ST_DIV && divisor_q != '0) |-> (acc_q < divisor_q))
	`VCS_ASSERT(a_done_holds, clk, arst_n,
		(state_q == ST_DONE && !ctrl.ack) |=> (state_q == ST_DONE))
	`VCS_ASSERT_NEVER(a_start_when_busy, clk, arst_n,
		ctrl.start && state_q != ST_IDLE)

endmodule

`default_nettype wire

### hw/rtl/vwap_crossover_signal.sv
// ----------------------------------------------------------------------------
// VWAP crossover signal: top level
// Volume-weighted average price from each tick and a buy/sell crossing
// signal against the previous last price.
// ----------------------------------------------------------------------------
// Usage:
//   Tick channel (tick_valid/tick_stall): last_price, turnover, volume,
//   ask_price, bid_price. Taken when tick_valid is high and tick_stall low.
//   Result channel (result_valid/result_stall): signal, order_price,
//   average_price, one result per tick.
//   A tick taken passes through 16 multiply steps of volume by
//   volume_multiplier and 63 restoring divide steps, all on one shared
//   49-bit adder/subtractor, then the output load that raises result_valid.
//   A new tick is not taken until the last one leaves the divider;
//   tick_stall is high while the unit is busy.
//   A finished result waits in the divider if the output register is still
//   stalled; the next tick is taken as soon as it moves to the output.
//   Reset clears the stored previous price (first tick gives no signal),
//   sets volume_multiplier to 1 and empties the result register.
//   volume_multiplier is written over the APB port at byte address 0.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "vwap_crossover_signal_defines.svh"

module vwap_crossover_signal (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [vcs_pkg::PADDR_W-1:0]   paddr,
	input  wire logic [vcs_pkg::PDATA_W-1:0]   pwdata,
	output logic      [vcs_pkg::PDATA_W-1:0]   prdata,
	output logic                               pready,
	input  wire logic                          tick_valid,
	output logic                               tick_stall,
	input  wire logic [vcs_pkg::PRICE_W-1:0]   last_price,
	input  wire logic [vcs_pkg::TURN_W-1:0]    turnover,
	input  wire logic [vcs_pkg::VOL_W-1:0]     volume,
	input  wire logic [vcs_pkg::PRICE_W-1:0]   ask_price,
	input  wire logic [vcs_pkg::PRICE_W-1:0]   bid_price,
	output logic                               result_valid,
	input  wire logic                          result_stall,
	output logic      [vcs_pkg::SIG_W-1:0]     signal,
	output logic      [vcs_pkg::PRICE_W-1:0]   order_price,
	output logic      [vcs_pkg::PRICE_W-1:0]   average_price
);

	logic [vcs_pkg::MULT_W-1:0]   vol_mult_q;
	logic [vcs_pkg::PRICE_W-1:0]  prev_price_q;
	logic [vcs_pkg::PRICE_W-1:0]  last_q;
	logic [vcs_pkg::PRICE_W-1:0]  ask_q;
	logic [vcs_pkg::PRICE_W-1:0]  bid_q;
	logic                         result_valid_q;
	logic [vcs_pkg::SIG_W-1:0]    signal_q;
	logic [vcs_pkg::PRICE_W-1:0]  order_price_q;
	logic [vcs_pkg::PRICE_W-1:0]  average_q;

	vcs_pkg::vcs_div_ctrl_t       div_ctrl;
	vcs_pkg::vcs_div_stat_t       div_stat;
	logic [vcs_pkg::TURN_W-1:0]   avg;

	logic                         cfg_wr;
	logic                         tick_acc;
	logic                         load;
	logic [vcs_pkg::TURN_W-1:0]   prev_x;
	logic [vcs_pkg::TURN_W-1:0]   cur_x;
	logic                         sell;
	logic                         buy;

	// config port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready
		&& (paddr[2] == vcs_pkg::REG_VOLUME_MULT);
	assign prdata = (paddr[2] == vcs_pkg::REG_VOLUME_MULT)
		? {{(vcs_pkg::PDATA_W-vcs_pkg::MULT_W){1'b0}}, vol_mult_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vol_mult_q <= vcs_pkg::VOLUME_MULT_RST;
		end else if (cfg_wr) begin
			vol_mult_q <= pwdata[vcs_pkg::MULT_W-1:0];
		end
	end

	// tick side
	assign tick_stall = div_stat.busy;
	assign tick_acc   = tick_valid && !tick_stall;
	assign load       = div_stat.done && (!result_valid_q || !result_stall);

	assign div_ctrl.start = tick_acc;
	assign div_ctrl.ack   = load;

	vcs_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (div_ctrl),
		.dividend (turnover),
		.volume   (volume),
		.mult     (vol_mult_q),
		.stat     (div_stat),
		.quotient (avg)
	);

	always_ff @(posedge clk) begin
		if (tick_acc) begin
			last_q <= last_price;
			ask_q  <= ask_price;
			bid_q  <= bid_price;
		end
	end

	// crossing test on the full quotient
	assign prev_x = {{(vcs_pkg::TURN_W-vcs_pkg::PRICE_W){1'b0}}, prev_price_q};
	assign cur_x  = {{(vcs_pkg::TURN_W-vcs_pkg::PRICE_W){1'b0}}, last_q};
	assign sell   = (prev_price_q != '0) && (prev_x > avg) && (cur_x < avg);
	assign buy    = (prev_price_q != '0) && (prev_x < avg) && (cur_x > avg);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_price_q   <= '0;
			result_valid_q <= 1'b0;
		end else begin
			if (load) begin
				prev_price_q   <= last_q;
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			if (sell) begin
				signal_q      <= vcs_pkg::SIG_SELL;
				order_price_q <= bid_q;
			end else if (buy) begin
				signal_q      <= vcs_pkg::SIG_BUY;
				order_price_q <= ask_q;
			end else begin
				signal_q      <= vcs_pkg::SIG_NONE;
				order_price_q <= '0;
			end
			average_q <= (avg[vcs_pkg::TURN_W-1:vcs_pkg::PRICE_W] != '0)
				? '1 : avg[vcs_pkg::PRICE_W-1:0];
		end
	end

	assign result_valid  = result_valid_q;
	assign signal        = signal_q;
	assign order_price   = order_price_q;
	assign average_price = average_q;

	`VCS_ASSERT(a_busy_after_tick, clk, arst_n,
		tick_acc |=> tick_stall)
	`VCS_ASSERT(a_no_order_no_price, clk, arst_n,
		(result_valid_q && signal_q == vcs_pkg::SIG_NONE) |-> (order_price_q == '0))
	`VCS_ASSERT_NEVER(a_buy_and_sell, clk, arst_n,
		load && buy && sell)

endmodule

`default_nettype wire
